>>> hdl/echirp_pkg.sv
// Shared constants, types and the quarter-wave sine generator for the chirp DDS.
package echirp_pkg;

    // Configuration register indexes
    localparam int                CFG_INDEX_BITS   = 3;
    localparam logic [2:0]        REG_START_INC    = 3'd0;
    localparam logic [2:0]        REG_SWEEP_RATIO  = 3'd1;
    localparam logic [2:0]        REG_START_PHASE  = 3'd2;
    localparam logic [2:0]        REG_SAMPLE_COUNT = 3'd3;
    localparam logic [2:0]        REG_AMPLITUDE    = 3'd4;

    // Register field widths and reset values
    localparam int                CFG_DATA_BITS    = 32;
    localparam int                CNT_FIELD_BITS   = 20;
    localparam int                AMP_BITS         = 15;
    localparam int                MAG_BITS         = 15;
    localparam int                SAMPLE_BITS      = 16;
    localparam logic [31:0]       RATIO_RESET      = 32'h4000_0000;
    localparam logic [19:0]       COUNT_RESET      = 20'd1;
    localparam logic [14:0]       AMP_RESET        = 15'd16383;

    // Fixed-point constants for the sine table
    localparam logic [63:0]       HALF_PI_Q30      = 64'd1686629713;
    localparam logic [63:0]       FULL_SCALE       = 64'd32767;

    // Flags carried beside the table address / magnitude down the pipe
    typedef struct packed {
        logic active;
        logic last;
        logic neg;
    } flags_t;

    // Quarter-wave magnitude for entry idx of a table with 2^tbits steps.
    // Odd Taylor series through x^13 in Q2.30, series steps truncated, final scale rounded.
    function automatic logic [14:0] quarter_sine(input logic [63:0] idx, input int tbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * idx) >> tbits;
        term = x;
        sum  = x;
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE)
        begin
            v = FULL_SCALE;
        end
        return v[14:0];
    endfunction

endpackage

>>> hdl/echirp_sine_rom.sv
// Quarter-wave sine ROM with registered read data.
module echirp_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [SINE_TABLE_BITS:0]     addr,
    output logic [echirp_pkg::MAG_BITS-1:0] mag
);
    import echirp_pkg::*;

    localparam int QLEN = 1 << SINE_TABLE_BITS;

    typedef logic [MAG_BITS-1:0] rom_t [QLEN+1];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i <= QLEN; i++)
        begin
            r[i] = quarter_sine(64'(i), SINE_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [MAG_BITS-1:0] mag_reg;

    // Registered table read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= SINE_ROM[addr];
        end
    end

    assign mag = mag_reg;

endmodule

>>> hdl/exponential_chirp_generator.sv
// Exponential chirp DDS: tick channel in, one signed sample per tick out.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------
//  tick     | tick_valid / tick_stall      | restart
//  result   | result_valid / result_stall  | sample, last, active
//  config   | cfg_valid / cfg_ready (=1)   | cfg_index, cfg_data
//
// One tick is accepted per cycle unless a stalled result backs up the pipe.
// Stages: state update and table address, sine ROM read, amplitude scaling.
// The phase/increment recurrence closes combinationally at the accept stage.
// Reset clears the pulse state and pipeline valids; registers take defaults.
// A stalled result holds; bubbles in the pipe still absorb new ticks.
module exponential_chirp_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int COUNT_BITS      = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // tick request
    input  logic                                    tick_valid,
    output logic                                    tick_stall,
    input  logic                                    restart,
    // result request
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [echirp_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    last,
    output logic                                    active,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [echirp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [echirp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import echirp_pkg::*;

    localparam int QLEN = 1 << SINE_TABLE_BITS;

    // Configuration registers
    logic [31:0]               start_inc_reg;
    logic [31:0]               sweep_ratio_reg;
    logic [31:0]               start_phase_reg;
    logic [CNT_FIELD_BITS-1:0] sample_count_reg;
    logic [AMP_BITS-1:0]       amplitude_reg;

    // Pulse state
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [PHASE_BITS-1:0]     inc_reg, inc_next;
    logic [COUNT_BITS-1:0]     index_reg, index_next;
    logic                      running_reg, running_next;

    // Pipeline
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      adv1, adv2, adv3, accept;
    flags_t                    f1_reg, f2_reg, f1_next;
    logic [SINE_TABLE_BITS:0]  addr1_reg, addr1_next;
    logic [MAG_BITS-1:0]       mag2;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                      last_reg, active_reg;

    // Accept-stage signals
    logic [PHASE_BITS+31:0]    phase_wide, inc_wide;
    logic [PHASE_BITS-1:0]     phase_eff, inc_eff;
    logic [COUNT_BITS-1:0]     index_eff, count_eff;
    logic                      run_eff, is_last;
    logic [1:0]                quad;
    logic [SINE_TABLE_BITS-1:0] kidx;
    logic [PHASE_BITS+15:0]    prod_lo, prod_hi;
    logic [PHASE_BITS+16:0]    prod_sum;
    logic [PHASE_BITS+2:0]     scaled;

    // Output-stage scaling
    logic [2*AMP_BITS-1:0]     amp_prod;
    logic [2*AMP_BITS:0]       amp_sum;
    logic [AMP_BITS-1:0]       amp_q;

    // Handshake: each stage moves when empty or when the next one moves
    assign adv3       = !v3_reg || !result_stall;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign tick_stall = !adv1;
    assign accept     = tick_valid && adv1;
    assign cfg_ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_inc_reg    <= '0;
            sweep_ratio_reg  <= RATIO_RESET;
            start_phase_reg  <= '0;
            sample_count_reg <= COUNT_RESET;
            amplitude_reg    <= AMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_INC:    start_inc_reg    <= cfg_data;
                REG_SWEEP_RATIO:  sweep_ratio_reg  <= cfg_data;
                REG_START_PHASE:  start_phase_reg  <= cfg_data;
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_FIELD_BITS-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[AMP_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Align 32-bit start values to the top of the accumulator
    assign phase_wide = {start_phase_reg, PHASE_BITS'(0)};
    assign inc_wide   = {start_inc_reg, PHASE_BITS'(0)};

    // Accept stage: restart load, sample flags, state advance
    always_comb
    begin
        run_eff   = restart || running_reg;
        phase_eff = restart ? phase_wide[PHASE_BITS+31 -: PHASE_BITS] : phase_reg;
        inc_eff   = restart ? inc_wide[PHASE_BITS+31 -: PHASE_BITS] : inc_reg;
        index_eff = restart ? '0 : index_reg;

        count_eff = COUNT_BITS'(sample_count_reg);
        if (count_eff == '0)
        begin
            count_eff = COUNT_BITS'(1);
        end
        is_last = index_eff >= (count_eff - COUNT_BITS'(1));

        // Table address from the quadrant and the next phase bits
        quad = phase_eff[PHASE_BITS-1 -: 2];
        kidx = phase_eff[PHASE_BITS-3 -: SINE_TABLE_BITS];
        if (quad[0])
        begin
            addr1_next = (SINE_TABLE_BITS+1)'(QLEN) - {1'b0, kidx};
        end
        else
        begin
            addr1_next = {1'b0, kidx};
        end

        f1_next.active = run_eff;
        f1_next.last   = run_eff && is_last;
        f1_next.neg    = quad[1];

        // Increment times Q2.30 ratio, in two 16-bit halves, saturated
        prod_lo  = inc_eff * sweep_ratio_reg[15:0];
        prod_hi  = inc_eff * sweep_ratio_reg[31:16];
        prod_sum = {1'b0, prod_hi} + (PHASE_BITS+17)'(prod_lo >> 16);
        scaled   = prod_sum[PHASE_BITS+16:14];

        phase_next   = phase_reg;
        inc_next     = inc_reg;
        index_next   = index_reg;
        running_next = running_reg;
        if (accept && run_eff)
        begin
            phase_next   = phase_eff + inc_eff;
            inc_next     = (scaled[PHASE_BITS+2 -: 3] != 3'b000) ? '1
                                                                 : scaled[PHASE_BITS-1:0];
            index_next   = index_eff + COUNT_BITS'(1);
            running_next = !is_last;
        end
    end

    // Pulse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            inc_reg     <= '0;
            index_reg   <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            inc_reg     <= inc_next;
            index_reg   <= index_next;
            running_reg <= running_next;
        end
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= accept;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            f1_reg    <= f1_next;
            addr1_reg <= addr1_next;
        end
        if (adv2)
        begin
            f2_reg <= f1_reg;
        end
        if (adv3)
        begin
            sample_reg <= sample_next;
            last_reg   <= f2_reg.last;
            active_reg <= f2_reg.active;
        end
    end

    echirp_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .en   (adv2),
        .addr (addr1_reg),
        .mag  (mag2)
    );

    // Amplitude scaling: divide by 32767 as (p + (p >> 15) + 1) >> 15
    always_comb
    begin
        amp_prod = amplitude_reg * mag2;
        amp_sum  = {1'b0, amp_prod} + (2*AMP_BITS+1)'(amp_prod >> AMP_BITS)
                   + (2*AMP_BITS+1)'(1);
        amp_q    = amp_sum[2*AMP_BITS-1:AMP_BITS];
        if (!f2_reg.active)
        begin
            sample_next = '0;
        end
        else if (f2_reg.neg)
        begin
            sample_next = -$signed({1'b0, amp_q});
        end
        else
        begin
            sample_next = $signed({1'b0, amp_q});
        end
    end

    assign result_valid = v3_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;
    assign active       = active_reg;

endmodule
